// ===== rtl/core/pphs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pphs_pkg
// Shared codes, constants and packet byte tables for the printer packet host
// sequencer.
// ----------------------------------------------------------------------------
package pphs_pkg;

    // Sequencer phases
    localparam logic [4:0] PH_IDLE   = 5'd0;
    localparam logic [4:0] PH_PROBE  = 5'd1;
    localparam logic [4:0] PH_INIT   = 5'd2;
    localparam logic [4:0] PH_DHDR   = 5'd3;
    localparam logic [4:0] PH_DFILL  = 5'd4;
    localparam logic [4:0] PH_DSEND  = 5'd5;
    localparam logic [4:0] PH_DTAIL  = 5'd6;
    localparam logic [4:0] PH_SETTLE = 5'd7;
    localparam logic [4:0] PH_EMPTY  = 5'd8;
    localparam logic [4:0] PH_PHDR   = 5'd9;
    localparam logic [4:0] PH_PFILL  = 5'd10;
    localparam logic [4:0] PH_PSEND  = 5'd11;
    localparam logic [4:0] PH_PTAIL  = 5'd12;
    localparam logic [4:0] PH_BUSY   = 5'd13;
    localparam logic [4:0] PH_BWAIT  = 5'd14;
    localparam logic [4:0] PH_READY  = 5'd15;
    localparam logic [4:0] PH_RWAIT  = 5'd16;

    // Request types
    localparam logic [1:0] REQ_HOST  = 2'd0;
    localparam logic [1:0] REQ_REPLY = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // Result destinations
    localparam logic DEST_LINK = 1'b0;
    localparam logic DEST_HOST = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_DATA_BLOCKS  = 2'd0;
    localparam logic [1:0] REG_SETTLE_TICKS = 2'd1;
    localparam logic [1:0] REG_POLL_TICKS   = 2'd2;
    localparam logic [1:0] REG_BUSY_MASK    = 2'd3;

    // Configuration reset values
    localparam logic [3:0]  DATA_BLOCKS_RST  = 4'd10;
    localparam logic [15:0] SETTLE_TICKS_RST = 16'd10;
    localparam logic [15:0] POLL_TICKS_RST   = 16'd100;
    localparam logic [7:0]  BUSY_MASK_RST    = 8'd2;

    // Sizes
    localparam int BLOCK_BYTES_DEF = 64;
    localparam int PRINT_ARG_BYTES = 4;
    localparam int BUF_DEPTH       = 64;
    localparam int BUF_AW          = $clog2(BUF_DEPTH);
    localparam int DC_W            = $clog2(BUF_DEPTH + 1);
    localparam int OQ_DEPTH        = 4;
    localparam int OQ_AW           = $clog2(OQ_DEPTH);

    // Packet bytes
    localparam logic [7:0] SYNC0      = 8'h88;
    localparam logic [7:0] SYNC1      = 8'h33;
    localparam logic [7:0] CMD_INIT   = 8'h01;
    localparam logic [7:0] CMD_DATA   = 8'h04;
    localparam logic [7:0] CMD_PRINT  = 8'h02;
    localparam logic [7:0] CMD_STATUS = 8'h0F;
    localparam logic [7:0] PROBE_OK   = 8'd129;
    localparam logic [3:0] PROBE_CHECK_IDX = 4'd8;

    // Host characters
    localparam logic [7:0] CHAR_PROBE = 8'h3F;  // '?'
    localparam logic [7:0] CHAR_JOB   = 8'h21;  // '!'
    localparam logic [7:0] CHAR_BLOCK = 8'h61;  // 'a'
    localparam logic [7:0] CHAR_BUSY  = 8'h50;  // 'P'
    localparam logic [7:0] CHAR_DONE  = 8'h4F;  // 'O'
    localparam logic [7:0] CHAR_ONE   = 8'h31;  // '1'
    localparam logic [7:0] CHAR_ZERO  = 8'h30;  // '0'

    typedef struct packed {
        logic       dest;
        logic [7:0] data;
        logic       last;
    } res_t;

    // Ten-byte command packet with no payload
    function automatic logic [7:0] cmd_byte(input logic [7:0] code, input logic [3:0] idx);
        logic [7:0] b;
        b = 8'h00;
        if (idx == 4'd0) begin
            b = SYNC0;
        end else if (idx == 4'd1) begin
            b = SYNC1;
        end else if (idx inside {4'd2, 4'd6}) begin
            b = code;
        end
        return b;
    endfunction

    function automatic logic [3:0] packet_len(input logic [4:0] ph);
        logic [3:0] n;
        case (ph)
            PH_DHDR, PH_PHDR: begin
                n = 4'd6;
            end
            PH_DTAIL, PH_PTAIL: begin
                n = 4'd4;
            end
            default: begin
                n = 4'd10;
            end
        endcase
        return n;
    endfunction

    function automatic logic [7:0] fixed_byte(input logic [4:0]  ph,
                                              input logic [3:0]  idx,
                                              input logic [15:0] len,
                                              input logic [15:0] cks);
        logic [15:0] arg_len;
        logic [7:0]  b;
        arg_len = 16'(PRINT_ARG_BYTES);
        b = 8'h00;
        case (ph)
            PH_PROBE, PH_INIT: begin
                b = cmd_byte(CMD_INIT, idx);
            end
            PH_EMPTY: begin
                b = cmd_byte(CMD_DATA, idx);
            end
            PH_BUSY, PH_READY: begin
                b = cmd_byte(CMD_STATUS, idx);
            end
            PH_DHDR, PH_PHDR: begin
                case (idx)
                    4'd0: b = SYNC0;
                    4'd1: b = SYNC1;
                    4'd2: b = (ph == PH_DHDR) ? CMD_DATA : CMD_PRINT;
                    4'd4: b = (ph == PH_DHDR) ? len[7:0] : arg_len[7:0];
                    4'd5: b = (ph == PH_DHDR) ? len[15:8] : arg_len[15:8];
                    default: b = 8'h00;
                endcase
            end
            PH_DTAIL, PH_PTAIL: begin
                if (idx == 4'd0) begin
                    b = cks[7:0];
                end else if (idx == 4'd1) begin
                    b = cks[15:8];
                end
            end
            default: begin
                b = 8'h00;
            end
        endcase
        return b;
    endfunction

endpackage

// ===== rtl/core/printer_packet_host_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// printer_packet_host_sequencer_core
// Byte-level host for a handheld printer link: probe and print job sequencing
// with a block buffer memory and a small result queue.
// ----------------------------------------------------------------------------
// The core takes one request per clock: a host byte, a link reply byte or a
// timer tick, and turns it into zero, one or two result bytes (link or host)
// in combinational sequencer logic. Requests are accepted while earlier
// results still wait in a four-entry result queue; s_ready drops only when
// fewer than two queue slots are free, so a steady stream of one request per
// cycle runs at full rate as long as m_ready stays high. A busy-status reply
// that produces two results fills two result queue slots. Data
// and print argument bytes are held in a 64 x 8 synchronous block buffer; the
// next byte to send is prefetched every cycle (registered read) with
// write forwarding, so no request waits on the memory. The buffer needs no
// clearing after reset: every entry is written before it is read.
// ----------------------------------------------------------------------------
module printer_packet_host_sequencer_core #(
    parameter int BLOCK_BYTES = pphs_pkg::BLOCK_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_in_byte,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_dest,
    output logic [7:0]  m_out_byte,
    output logic        m_last,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import pphs_pkg::*;

    localparam logic [DC_W-1:0] BLOCK_LIM = DC_W'(BLOCK_BYTES);
    localparam logic [DC_W-1:0] ARG_LIM   = DC_W'(PRINT_ARG_BYTES);

    // Configuration registers
    logic [3:0]  data_blocks_reg;
    logic [15:0] settle_ticks_reg;
    logic [15:0] poll_ticks_reg;
    logic [7:0]  busy_mask_reg;

    // Sequencer state
    logic [4:0]      phase_reg, phase_next;
    logic [3:0]      packet_index_reg, packet_index_next;
    logic [3:0]      block_count_reg, block_count_next;
    logic [DC_W-1:0] data_count_reg, data_count_next;
    logic [15:0]     checksum_reg, checksum_next;
    logic [15:0]     wait_count_reg, wait_count_next;

    // Block buffer
    logic [7:0]        buf_mem [BUF_DEPTH];
    logic              buf_we;
    logic [BUF_AW-1:0] buf_waddr;
    logic [BUF_AW-1:0] buf_raddr;
    logic [7:0]        buf_rdata_reg;
    logic              fwd_hit_reg;
    logic [7:0]        fwd_data_reg;
    logic [7:0]        pf_byte;

    // Result queue
    res_t             oq_mem [OQ_DEPTH];
    logic [OQ_AW-1:0] oq_wptr_reg, oq_rptr_reg;
    logic [OQ_AW:0]   oq_count_reg;
    logic [1:0]       n_res;
    res_t             res0, res1;
    logic             accept, pop;
    logic [15:0]      data_len;

    assign accept   = s_valid && s_ready;
    assign pop      = m_valid && m_ready;
    assign s_ready  = (oq_count_reg <= (OQ_AW + 1)'(OQ_DEPTH - 2));
    assign data_len = 16'(32'(data_blocks_reg) * 32'(BLOCK_BYTES));

    // Prefetched buffer byte: registered read, bypassed by a same-cycle write
    assign pf_byte = fwd_hit_reg ? fwd_data_reg : buf_rdata_reg;

    // Fill phases store the host byte at the current fill position
    assign buf_we    = accept && (s_req_type == REQ_HOST) &&
                       ((phase_reg == PH_DFILL) || (phase_reg == PH_PFILL));
    assign buf_waddr = data_count_reg[BUF_AW-1:0];

    // Prefetch the entry the next send will need: the following byte while
    // sending, entry zero otherwise (first byte of the next block)
    always_comb begin
        logic [DC_W-1:0] nxt;
        nxt = data_count_next + DC_W'(1);
        if ((phase_next == PH_DSEND) || (phase_next == PH_PSEND)) begin
            buf_raddr = nxt[BUF_AW-1:0];
        end else begin
            buf_raddr = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (buf_we) begin
            buf_mem[buf_waddr] <= s_in_byte;
        end
        buf_rdata_reg <= buf_mem[buf_raddr];
        fwd_hit_reg   <= buf_we && (buf_waddr == buf_raddr);
        fwd_data_reg  <= s_in_byte;
    end

    // Sequencer next state and results
    always_comb begin
        logic [15:0]     cks_mid;
        logic [7:0]      snd;
        logic [DC_W-1:0] dc_inc;
        logic [DC_W-1:0] lim;
        logic [4:0]      bc_inc;
        logic [3:0]      pi_inc;
        logic [4:0]      tgt;
        logic            busy;

        phase_next        = phase_reg;
        packet_index_next = packet_index_reg;
        block_count_next  = block_count_reg;
        data_count_next   = data_count_reg;
        checksum_next     = checksum_reg;
        wait_count_next   = wait_count_reg;
        n_res = 2'd0;
        res0  = '{dest: DEST_LINK, data: 8'h00, last: 1'b1};
        res1  = '{dest: DEST_LINK, data: 8'h00, last: 1'b1};

        cks_mid = checksum_reg;
        snd     = pf_byte;
        dc_inc  = data_count_reg + DC_W'(1);
        lim     = ((phase_reg == PH_DFILL) || (phase_reg == PH_DSEND)) ? BLOCK_LIM : ARG_LIM;
        bc_inc  = {1'b0, block_count_reg} + 5'd1;
        pi_inc  = packet_index_reg + 4'd1;
        tgt     = PH_IDLE;
        busy    = (s_in_byte & busy_mask_reg) != 8'h00;

        if (accept) begin
            case (s_req_type)
                REQ_HOST: begin
                    if (phase_reg == PH_IDLE) begin
                        if (s_in_byte == CHAR_PROBE) begin
                            checksum_next     = '0;
                            phase_next        = PH_PROBE;
                            packet_index_next = '0;
                            n_res = 2'd1;
                            res0.data = SYNC0;
                        end else if (s_in_byte == CHAR_JOB) begin
                            phase_next        = PH_INIT;
                            packet_index_next = '0;
                            n_res = 2'd1;
                            res0.data = SYNC0;
                        end
                    end else if ((phase_reg == PH_DFILL) || (phase_reg == PH_PFILL)) begin
                        if (dc_inc >= lim) begin
                            // block complete: send its first byte now
                            snd = (data_count_reg[BUF_AW-1:0] == '0) ? s_in_byte : pf_byte;
                            data_count_next = '0;
                            phase_next = (phase_reg == PH_DFILL) ? PH_DSEND : PH_PSEND;
                            checksum_next = checksum_reg + 16'(snd);
                            n_res = 2'd1;
                            res0.data = snd;
                        end else begin
                            data_count_next = dc_inc;
                        end
                    end
                end
                REQ_REPLY: begin
                    case (phase_reg)
                        PH_DSEND, PH_PSEND: begin
                            data_count_next = dc_inc;
                            n_res = 2'd1;
                            if (dc_inc < lim) begin
                                checksum_next = checksum_reg + 16'(pf_byte);
                                res0.data = pf_byte;
                            end else if (phase_reg == PH_DSEND) begin
                                block_count_next = bc_inc[3:0];
                                if (bc_inc < {1'b0, data_blocks_reg}) begin
                                    res0 = '{dest: DEST_HOST, data: CHAR_BLOCK, last: 1'b1};
                                    phase_next = PH_DFILL;
                                    data_count_next = '0;
                                end else begin
                                    phase_next = PH_DTAIL;
                                    packet_index_next = '0;
                                    res0.data = checksum_reg[7:0];
                                end
                            end else begin
                                phase_next = PH_PTAIL;
                                packet_index_next = '0;
                                res0.data = checksum_reg[7:0];
                            end
                        end
                        PH_PROBE, PH_INIT, PH_DHDR, PH_DTAIL, PH_EMPTY,
                        PH_PHDR, PH_PTAIL, PH_BUSY, PH_READY: begin
                            // latch the probe verdict from the ninth reply
                            if ((phase_reg == PH_PROBE) &&
                                (packet_index_reg == PROBE_CHECK_IDX)) begin
                                cks_mid = {15'd0, s_in_byte == PROBE_OK};
                            end
                            checksum_next = cks_mid;
                            if (pi_inc < packet_len(phase_reg)) begin
                                packet_index_next = pi_inc;
                                n_res = 2'd1;
                                res0.data = fixed_byte(phase_reg, pi_inc, data_len, cks_mid);
                            end else begin
                                case (phase_reg)
                                    PH_PROBE: begin
                                        n_res = 2'd1;
                                        res0 = '{dest: DEST_HOST,
                                                 data: cks_mid[0] ? CHAR_ONE : CHAR_ZERO,
                                                 last: 1'b1};
                                        phase_next = PH_IDLE;
                                    end
                                    PH_INIT: begin
                                        checksum_next = 16'(CMD_DATA) + 16'(data_len[7:0]) +
                                                        16'(data_len[15:8]);
                                        phase_next = PH_DHDR;
                                        packet_index_next = '0;
                                        n_res = 2'd1;
                                        res0.data = SYNC0;
                                    end
                                    PH_DHDR: begin
                                        block_count_next = '0;
                                        n_res = 2'd1;
                                        if (data_blocks_reg != 4'd0) begin
                                            res0 = '{dest: DEST_HOST, data: CHAR_BLOCK,
                                                     last: 1'b1};
                                            phase_next = PH_DFILL;
                                            data_count_next = '0;
                                        end else begin
                                            phase_next = PH_DTAIL;
                                            packet_index_next = '0;
                                            res0.data = cks_mid[7:0];
                                        end
                                    end
                                    PH_DTAIL: begin
                                        if (settle_ticks_reg == 16'd0) begin
                                            phase_next = PH_EMPTY;
                                            packet_index_next = '0;
                                            n_res = 2'd1;
                                            res0.data = SYNC0;
                                        end else begin
                                            wait_count_next = settle_ticks_reg;
                                            phase_next = PH_SETTLE;
                                        end
                                    end
                                    PH_EMPTY: begin
                                        checksum_next = 16'(CMD_PRINT) +
                                                        16'(PRINT_ARG_BYTES % 256) +
                                                        16'(PRINT_ARG_BYTES / 256);
                                        phase_next = PH_PHDR;
                                        packet_index_next = '0;
                                        n_res = 2'd1;
                                        res0.data = SYNC0;
                                    end
                                    PH_PHDR: begin
                                        n_res = 2'd1;
                                        res0 = '{dest: DEST_HOST, data: CHAR_ONE, last: 1'b1};
                                        phase_next = PH_PFILL;
                                        data_count_next = '0;
                                    end
                                    PH_PTAIL: begin
                                        phase_next = PH_BUSY;
                                        packet_index_next = '0;
                                        n_res = 2'd1;
                                        res0.data = SYNC0;
                                    end
                                    PH_BUSY, PH_READY: begin
                                        if ((phase_reg == PH_BUSY) && busy) begin
                                            // report busy, then poll for ready at once
                                            n_res = 2'd2;
                                            res0 = '{dest: DEST_HOST, data: CHAR_BUSY,
                                                     last: 1'b0};
                                            res1 = '{dest: DEST_LINK, data: SYNC0,
                                                     last: 1'b1};
                                            phase_next = PH_READY;
                                            packet_index_next = '0;
                                        end else if ((phase_reg == PH_READY) && !busy) begin
                                            n_res = 2'd1;
                                            res0 = '{dest: DEST_HOST, data: CHAR_DONE,
                                                     last: 1'b1};
                                            phase_next = PH_IDLE;
                                        end else if (poll_ticks_reg == 16'd0) begin
                                            packet_index_next = '0;
                                            n_res = 2'd1;
                                            res0.data = SYNC0;
                                        end else begin
                                            wait_count_next = poll_ticks_reg;
                                            phase_next = (phase_reg == PH_BUSY) ?
                                                         PH_BWAIT : PH_RWAIT;
                                        end
                                    end
                                    default: begin
                                        phase_next = phase_reg;
                                    end
                                endcase
                            end
                        end
                        default: begin
                            phase_next = phase_reg;
                        end
                    endcase
                end
                REQ_TICK: begin
                    case (phase_reg)
                        PH_SETTLE: tgt = PH_EMPTY;
                        PH_BWAIT:  tgt = PH_BUSY;
                        PH_RWAIT:  tgt = PH_READY;
                        default:   tgt = PH_IDLE;
                    endcase
                    if (tgt != PH_IDLE) begin
                        if (wait_count_reg > 16'd1) begin
                            wait_count_next = wait_count_reg - 16'd1;
                        end else begin
                            // delay over: start the next packet
                            wait_count_next = '0;
                            phase_next = tgt;
                            packet_index_next = '0;
                            n_res = 2'd1;
                            res0.data = SYNC0;
                        end
                    end
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Control and configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_blocks_reg  <= DATA_BLOCKS_RST;
            settle_ticks_reg <= SETTLE_TICKS_RST;
            poll_ticks_reg   <= POLL_TICKS_RST;
            busy_mask_reg    <= BUSY_MASK_RST;
            phase_reg        <= PH_IDLE;
            packet_index_reg <= '0;
            block_count_reg  <= '0;
            data_count_reg   <= '0;
            checksum_reg     <= '0;
            wait_count_reg   <= '0;
            oq_wptr_reg      <= '0;
            oq_rptr_reg      <= '0;
            oq_count_reg     <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_DATA_BLOCKS:  data_blocks_reg  <= cfg_data[3:0];
                    REG_SETTLE_TICKS: settle_ticks_reg <= cfg_data;
                    REG_POLL_TICKS:   poll_ticks_reg   <= cfg_data;
                    REG_BUSY_MASK:    busy_mask_reg    <= cfg_data[7:0];
                    default:          busy_mask_reg    <= busy_mask_reg;
                endcase
            end
            phase_reg        <= phase_next;
            packet_index_reg <= packet_index_next;
            block_count_reg  <= block_count_next;
            data_count_reg   <= data_count_next;
            checksum_reg     <= checksum_next;
            wait_count_reg   <= wait_count_next;
            oq_wptr_reg      <= oq_wptr_reg + OQ_AW'(n_res);
            oq_rptr_reg      <= oq_rptr_reg + OQ_AW'(pop);
            oq_count_reg     <= oq_count_reg + (OQ_AW + 1)'(n_res) - (OQ_AW + 1)'(pop);
        end
    end

    // Result queue storage
    always_ff @(posedge aclk) begin
        if (n_res != 2'd0) begin
            oq_mem[oq_wptr_reg] <= res0;
        end
        if (n_res == 2'd2) begin
            oq_mem[oq_wptr_reg + OQ_AW'(1)] <= res1;
        end
    end

    assign m_valid    = (oq_count_reg != '0);
    assign m_dest     = oq_mem[oq_rptr_reg].dest;
    assign m_out_byte = oq_mem[oq_rptr_reg].data;
    assign m_last     = oq_mem[oq_rptr_reg].last;

    // Checks
    a_oq_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        oq_count_reg <= (OQ_AW + 1)'(OQ_DEPTH))
        else $error("result queue overflow");

    a_wait_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        ((phase_reg == PH_SETTLE) || (phase_reg == PH_BWAIT) || (phase_reg == PH_RWAIT))
        |-> (wait_count_reg != 16'd0))
        else $error("wait phase with empty wait count");

    a_block_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ((phase_reg == PH_DFILL) || (phase_reg == PH_DSEND)) |-> (data_count_reg < BLOCK_LIM))
        else $error("data byte count beyond block");

    a_arg_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ((phase_reg == PH_PFILL) || (phase_reg == PH_PSEND)) |-> (data_count_reg < ARG_LIM))
        else $error("print argument count beyond limit");

endmodule

// ===== bench/tb_printer_packet_host_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_printer_packet_host_sequencer_core
// Self-checking bench for the printer packet host sequencer. A software copy
// of the sequencer predicts every link and host byte from the accepted
// requests. Stimulus follows the predicted phase, so probes and whole print
// jobs run to the end. Stray requests, random back-pressure and register
// changes between jobs and in the middle of a job are mixed in.
// ----------------------------------------------------------------------------
module tb_printer_packet_host_sequencer_core;
    import pphs_pkg::*;

    localparam logic [1:0] REQ_UNUSED      = 2'd3;   // request type the block ignores
    localparam logic [3:0] STATUS_LAST_IDX = 4'd9;   // reply here carries the busy bits
    localparam logic [3:0] DHDR_LAST_IDX   = 4'd5;   // last byte of the data header
    localparam int         QUIET_CYCLES    = 16;
    localparam int         HOLD_CYCLES     = 300;
    localparam int         WATCHDOG_LIMIT  = 5000;
    localparam int         RANDOM_ITEMS    = 28;
    localparam int         NOISE_PCT       = 8;

    class print_job_scoreboard;
        // register copies
        logic [3:0]  blocks;
        logic [15:0] settle;
        logic [15:0] poll;
        logic [7:0]  mask;
        // sequencer state copies
        logic [4:0]  phase;
        logic [3:0]  pkt_idx;
        logic [3:0]  blk_cnt;
        logic [6:0]  fill_cnt;
        logic [15:0] cks;
        logic [15:0] wait_left;
        logic [7:0]  block_mem [BUF_DEPTH];
        // bytes caused by the request being predicted, then all bytes still owed
        res_t        step_out[$];
        res_t        pending_bytes[$];
        int          errors;

        function new();
            blocks    = DATA_BLOCKS_RST;
            settle    = SETTLE_TICKS_RST;
            poll      = POLL_TICKS_RST;
            mask      = BUSY_MASK_RST;
            phase     = PH_IDLE;
            pkt_idx   = 4'd0;
            blk_cnt   = 4'd0;
            fill_cnt  = 7'd0;
            cks       = 16'd0;
            wait_left = 16'd0;
            errors    = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [15:0] val);
            case (idx)
                REG_DATA_BLOCKS: begin
                    blocks = val[3:0];
                end
                REG_SETTLE_TICKS: begin
                    settle = val;
                end
                REG_POLL_TICKS: begin
                    poll = val;
                end
                default: begin
                    mask = val[7:0];
                end
            endcase
        endfunction

        function void emit(logic dest, logic [7:0] b);
            res_t r;
            r.dest = dest;
            r.data = b;
            r.last = 1'b0;
            // no request ever causes more than two bytes
            if (step_out.size() < 2) step_out.push_back(r);
        endfunction

        function logic [15:0] job_len();
            return {6'd0, blocks, 6'd0};
        endfunction

        function logic [3:0] pkt_len(logic [4:0] ph);
            if (ph == PH_DHDR || ph == PH_PHDR) return 4'd6;
            if (ph == PH_DTAIL || ph == PH_PTAIL) return 4'd4;
            return 4'd10;
        endfunction

        function logic [7:0] packet_byte(logic [4:0] ph, logic [3:0] idx);
            logic [15:0] len;
            logic [7:0]  code;
            len  = (ph == PH_DHDR) ? job_len() : 16'(PRINT_ARG_BYTES);
            code = CMD_INIT;
            if (ph == PH_EMPTY) code = CMD_DATA;
            else if (ph == PH_BUSY || ph == PH_READY) code = CMD_STATUS;
            // trailer: checksum low, checksum high, two zero bytes
            if (ph == PH_DTAIL || ph == PH_PTAIL) begin
                if (idx == 4'd0) return cks[7:0];
                if (idx == 4'd1) return cks[15:8];
                return 8'h00;
            end
            if (idx == 4'd0) return SYNC0;
            if (idx == 4'd1) return SYNC1;
            if (ph == PH_DHDR || ph == PH_PHDR) begin
                if (idx == 4'd2) return (ph == PH_DHDR) ? CMD_DATA : CMD_PRINT;
                if (idx == 4'd4) return len[7:0];
                if (idx == 4'd5) return len[15:8];
                return 8'h00;
            end
            return (idx == 4'd2 || idx == 4'd6) ? code : 8'h00;
        endfunction

        function void begin_packet(logic [4:0] ph);
            phase   = ph;
            pkt_idx = 4'd0;
            emit(DEST_LINK, packet_byte(ph, 4'd0));
        endfunction

        function void next_block();
            if (blk_cnt < blocks) begin
                emit(DEST_HOST, CHAR_BLOCK);
                phase    = PH_DFILL;
                fill_cnt = 7'd0;
            end else begin
                begin_packet(PH_DTAIL);
            end
        endfunction

        function void send_stored();
            logic [7:0] b;
            b   = block_mem[fill_cnt[5:0]];
            cks = cks + 16'(b);
            emit(DEST_LINK, b);
        endfunction

        function void poll_again(logic [4:0] wait_ph, logic [4:0] poll_ph);
            if (poll == 16'd0) begin
                begin_packet(poll_ph);
            end else begin
                wait_left = poll;
                phase     = wait_ph;
            end
        endfunction

        function void packet_done(logic [7:0] reply);
            logic [15:0] len;
            len = job_len();
            case (phase)
                PH_PROBE: begin
                    emit(DEST_HOST, cks[0] ? CHAR_ONE : CHAR_ZERO);
                    phase = PH_IDLE;
                end
                PH_INIT: begin
                    cks = 16'(CMD_DATA) + 16'(len[7:0]) + 16'(len[15:8]);
                    begin_packet(PH_DHDR);
                end
                PH_DHDR: begin
                    blk_cnt = 4'd0;
                    next_block();
                end
                PH_DTAIL: begin
                    if (settle == 16'd0) begin
                        begin_packet(PH_EMPTY);
                    end else begin
                        wait_left = settle;
                        phase     = PH_SETTLE;
                    end
                end
                PH_EMPTY: begin
                    cks = 16'(CMD_PRINT) + 16'(PRINT_ARG_BYTES);
                    begin_packet(PH_PHDR);
                end
                PH_PHDR: begin
                    emit(DEST_HOST, CHAR_ONE);
                    phase    = PH_PFILL;
                    fill_cnt = 7'd0;
                end
                PH_PTAIL: begin
                    begin_packet(PH_BUSY);
                end
                PH_BUSY: begin
                    if ((reply & mask) != 8'd0) begin
                        emit(DEST_HOST, CHAR_BUSY);
                        begin_packet(PH_READY);
                    end else begin
                        poll_again(PH_BWAIT, PH_BUSY);
                    end
                end
                PH_READY: begin
                    if ((reply & mask) == 8'd0) begin
                        emit(DEST_HOST, CHAR_DONE);
                        phase = PH_IDLE;
                    end else begin
                        poll_again(PH_RWAIT, PH_READY);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void take_host(logic [7:0] b);
            if (phase == PH_IDLE) begin
                if (b == CHAR_PROBE) begin
                    cks = 16'd0;
                    begin_packet(PH_PROBE);
                end else if (b == CHAR_JOB) begin
                    begin_packet(PH_INIT);
                end
            end else if (phase == PH_DFILL || phase == PH_PFILL) begin
                block_mem[fill_cnt[5:0]] = b;
                fill_cnt = fill_cnt + 7'd1;
                if (phase == PH_DFILL && fill_cnt >= 7'(BLOCK_BYTES_DEF)) begin
                    fill_cnt = 7'd0;
                    phase    = PH_DSEND;
                    send_stored();
                end else if (phase == PH_PFILL && fill_cnt >= 7'(PRINT_ARG_BYTES)) begin
                    fill_cnt = 7'd0;
                    phase    = PH_PSEND;
                    send_stored();
                end
            end
        endfunction

        function void take_reply(logic [7:0] r);
            if (phase == PH_DSEND || phase == PH_PSEND) begin
                fill_cnt = fill_cnt + 7'd1;
                if (fill_cnt < ((phase == PH_DSEND) ? 7'(BLOCK_BYTES_DEF) :
                                                      7'(PRINT_ARG_BYTES))) begin
                    send_stored();
                end else if (phase == PH_DSEND) begin
                    blk_cnt = blk_cnt + 4'd1;
                    next_block();
                end else begin
                    begin_packet(PH_PTAIL);
                end
                return;
            end
            case (phase)
                PH_PROBE, PH_INIT, PH_DHDR, PH_DTAIL, PH_EMPTY,
                PH_PHDR, PH_PTAIL, PH_BUSY, PH_READY: begin
                    if (phase == PH_PROBE && pkt_idx == PROBE_CHECK_IDX)
                        cks = (r == PROBE_OK) ? 16'd1 : 16'd0;
                    if (5'(pkt_idx) + 5'd1 < 5'(pkt_len(phase))) begin
                        pkt_idx = pkt_idx + 4'd1;
                        emit(DEST_LINK, packet_byte(phase, pkt_idx));
                    end else begin
                        packet_done(r);
                    end
                end
                default: begin
                end
            endcase
        endfunction

        function void take_tick();
            logic [4:0] nxt;
            if (phase == PH_SETTLE) nxt = PH_EMPTY;
            else if (phase == PH_BWAIT) nxt = PH_BUSY;
            else if (phase == PH_RWAIT) nxt = PH_READY;
            else return;
            if (wait_left > 16'd0) wait_left = wait_left - 16'd1;
            if (wait_left == 16'd0) begin_packet(nxt);
        endfunction

        // Predict the bytes one accepted request causes and queue them.
        function void note_request(logic [1:0] kind, logic [7:0] b);
            step_out.delete();
            case (kind)
                REQ_HOST: begin
                    take_host(b);
                end
                REQ_REPLY: begin
                    take_reply(b);
                end
                REQ_TICK: begin
                    take_tick();
                end
                default: begin
                end
            endcase
            if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
            foreach (step_out[i]) pending_bytes.push_back(step_out[i]);
        endfunction

        function void check_result(logic dest, logic [7:0] b, logic lst);
            res_t want;
            if (pending_bytes.size() == 0) begin
                $error("unexpected result: dest %0d, out_byte 0x%02h, last %0d",
                       dest, b, lst);
                errors++;
                return;
            end
            want = pending_bytes.pop_front();
            if (dest !== want.dest) begin
                $error("dest: expected %0d, got %0d", want.dest, dest);
                errors++;
            end
            if (b !== want.data) begin
                $error("out_byte: expected 0x%02h, got 0x%02h", want.data, b);
                errors++;
            end
            if (lst !== want.last) begin
                $error("last: expected %0d, got %0d", want.last, lst);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn    = 1'b0;
    logic        s_valid    = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = REQ_HOST;
    logic [7:0]  s_in_byte  = 8'h00;
    logic        m_valid;
    logic        m_ready    = 1'b0;
    logic        m_dest;
    logic [7:0]  m_out_byte;
    logic        m_last;
    logic        cfg_we     = 1'b0;
    logic [1:0]  cfg_index  = REG_DATA_BLOCKS;
    logic [15:0] cfg_data   = 16'd0;

    // idling knobs, percent of cycles
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    // bump hold_seq to make the receiver hold off for HOLD_CYCLES
    logic [7:0]  hold_seq       = 8'd0;
    logic [7:0]  hold_seen      = 8'd0;
    int          hold_left      = 0;
    int          quiet_cycles   = 0;

    print_job_scoreboard sb;

    printer_packet_host_sequencer_core uut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_req_type (s_req_type),
        .s_in_byte  (s_in_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_dest     (m_dest),
        .m_out_byte (m_out_byte),
        .m_last     (m_last),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Result side: check each accepted byte, then pick m_ready for the next
    // cycle. A pending hold-off overrides the random stalls.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_dest, m_out_byte, m_last);
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // Watchdog: abort when neither channel moves for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles = quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Offer one request and return at the edge that accepts it. Leave valid
    // high so a back-to-back request needs no second assignment this step.
    task automatic send_req(input logic [1:0] kind, input logic [7:0] b);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_req_type <= kind;
        s_in_byte  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(kind, b);
    endtask

    // Drop valid, wait for every owed byte, then let requests that cause no
    // byte finish inside the block.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.pending_bytes.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    // Write all four registers on consecutive edges while the block is quiet.
    task automatic program_regs(input logic [3:0] blocks, input logic [15:0] settle,
                                input logic [15:0] poll, input logic [7:0] mask);
        logic [15:0] vals [4];
        vals[REG_DATA_BLOCKS]  = 16'(blocks);
        vals[REG_SETTLE_TICKS] = settle;
        vals[REG_POLL_TICKS]   = poll;
        vals[REG_BUSY_MASK]    = 16'(mask);
        wait_quiet();
        for (int i = 0; i < 4; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= 2'(i);
            cfg_data  <= vals[i];
            @(posedge aclk);
            sb.set_reg(2'(i), vals[i]);
        end
        cfg_we <= 1'b0;
    endtask

    // Link reply with random content, steered at the bytes that matter:
    // the probe check byte and the busy bits of a status reply.
    function automatic logic [7:0] pick_reply();
        logic [7:0] r;
        logic       go;
        r  = 8'($urandom);
        go = ($urandom_range(99, 0) < 75);
        if (sb.phase == PH_PROBE && sb.pkt_idx == PROBE_CHECK_IDX) begin
            if ($urandom_range(1, 0) == 1) r = PROBE_OK;
        end else if (sb.phase == PH_BUSY && sb.pkt_idx == STATUS_LAST_IDX) begin
            r = go ? (r | sb.mask) : (r & ~sb.mask);
        end else if (sb.phase == PH_READY && sb.pkt_idx == STATUS_LAST_IDX) begin
            r = go ? (r & ~sb.mask) : (r | sb.mask);
        end
        return r;
    endfunction

    // Send the request the predicted phase is waiting for, or a stray one.
    task automatic feed_job(input int noise_pct);
        logic [1:0] kind;
        logic [7:0] b;
        b = 8'($urandom);
        if ($urandom_range(99, 0) < noise_pct) begin
            kind = 2'($urandom_range(3, 0));
        end else begin
            case (sb.phase)
                PH_IDLE: begin
                    kind = REQ_HOST;
                    b    = ($urandom_range(99, 0) < 40) ? CHAR_PROBE : CHAR_JOB;
                end
                PH_DFILL, PH_PFILL: begin
                    kind = REQ_HOST;
                end
                PH_SETTLE, PH_BWAIT, PH_RWAIT: begin
                    kind = REQ_TICK;
                end
                default: begin
                    kind = REQ_REPLY;
                    b    = pick_reply();
                end
            endcase
        end
        send_req(kind, b);
    endtask

    // Probe with a chosen check byte at the ninth reply.
    task automatic run_probe(input logic [7:0] verdict);
        send_req(REQ_HOST, CHAR_PROBE);
        while (sb.phase == PH_PROBE)
            send_req(REQ_REPLY, (sb.pkt_idx == PROBE_CHECK_IDX) ? verdict : 8'($urandom));
    endtask

    initial begin
        int         n;
        int         polls;
        logic [4:0] was;
        int         stall_tbl [4][2];
        stall_tbl = '{'{0, 0}, '{67, 0}, '{0, 67}, '{31, 31}};
        sb = new();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Stray requests while idle: unused type, odd host bytes, reply, tick.
        send_req(REQ_UNUSED, CHAR_PROBE);
        send_req(REQ_HOST, 8'h00);
        send_req(REQ_HOST, 8'hFF);
        send_req(REQ_REPLY, 8'hFF);
        send_req(REQ_TICK, 8'h00);
        // Probe that finds the printer, then one off by a bit.
        run_probe(PROBE_OK);
        run_probe(8'd128);

        // Header announces fifteen blocks; cut the job down to an empty data
        // packet before the header ends. No delays, every status bit means busy.
        program_regs(4'd15, 16'd0, 16'd0, 8'hFF);
        send_req(REQ_HOST, CHAR_JOB);
        while (!((sb.phase == PH_DHDR) && (sb.pkt_idx == DHDR_LAST_IDX))) feed_job(0);
        program_regs(4'd0, 16'd0, 16'd0, 8'hFF);
        while (sb.phase != PH_IDLE) feed_job(0);

        // One data block and short waits. No busy bits at all: the job polls
        // forever until the mask changes. Change mask and poll time while a
        // poll wait is under way.
        send_idle_pct  = 31;
        recv_stall_pct = 31;
        program_regs(4'd1, 16'd3, 16'd2, 8'h00);
        send_req(REQ_HOST, CHAR_JOB);
        polls = 0;
        while (polls < 2) begin
            was = sb.phase;
            feed_job(0);
            if (was == PH_BUSY && sb.phase == PH_BWAIT) polls++;
        end
        program_regs(4'd1, 16'd3, 16'd0, 8'h80);
        while (sb.phase != PH_IDLE) feed_job(0);

        // Random jobs and probes under each idling mix; a job left open runs
        // on under the next mix's registers.
        for (int m = 0; m < 4; m++) begin
            send_idle_pct  = stall_tbl[m][0];
            recv_stall_pct = stall_tbl[m][1];
            program_regs(4'($urandom_range(2, 0)), 16'($urandom_range(4, 0)),
                         16'($urandom_range(4, 0)), 8'($urandom_range(255, 1)));
            n = 0;
            while (n < RANDOM_ITEMS) begin
                // hold the result side off long enough to back up the input
                if (m == 0 && n == 5) hold_seq <= hold_seq + 8'd1;
                feed_job(NOISE_PCT);
                n++;
            end
        end

        wait_quiet();
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
